[sv/svsd_pkg.sv]
// shared types and codes for the serialized value stream decoder
package svsd_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned CONT_W   = 2;

    localparam logic [KIND_W-1:0] KIND_BYTE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BOOL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INT      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LONG     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_VARINT32 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_VARINT64 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_STRING   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_VALUE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_LEAD  = 3'd4;

    localparam logic [IDX_W-1:0] VARINT32_MAX_BYTES = 4'd5;
    localparam logic [IDX_W-1:0] VARINT64_MAX_BYTES = 4'd9;
    localparam logic [IDX_W-1:0] VARINT64_LAST_IDX  = 4'd8;
    localparam logic [IDX_W-1:0] LEN_MAX_BYTES      = 4'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIXED,
        PH_VARINT,
        PH_ASCII,
        PH_LEN,
        PH_UTF8
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [KIND_W-1:0]   kind;
        logic                zigzag;
        logic [VALUE_W-1:0]  acc;
        logic [IDX_W-1:0]    idx;
        logic [COUNT_W-1:0]  chars_left;
        logic [UNIT_W-1:0]   partial;
        logic [CONT_W-1:0]   cont_left;
    } t_dec_state;

    typedef struct packed {
        logic                have;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

endpackage

[sv/svsd_step.sv]
// next-state and result logic for one byte beat
module svsd_step (
    input  svsd_pkg::t_dec_state             i_state,
    input  logic [svsd_pkg::KIND_W-1:0]      i_kind,
    input  logic                             i_zigzag,
    input  logic [svsd_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             i_end_of_buffer,
    output svsd_pkg::t_dec_state             o_state,
    output svsd_pkg::t_result                o_result
);

    svsd_pkg::t_dec_state             n;
    svsd_pkg::t_result                r;
    logic                             do_num;
    logic                             do_len;
    logic                             do_trunc;
    logic [6:0]                       sh;
    logic [svsd_pkg::IDX_W-1:0]       nbytes;
    logic [svsd_pkg::IDX_W-1:0]       maxb;
    logic [31:0]                      u32;
    logic [svsd_pkg::VALUE_W-1:0]     u64;
    logic [svsd_pkg::BYTE_W-1:0]      b;

    assign b = i_data_byte;

    always_comb begin
        n        = i_state;
        r        = '0;
        r.status = svsd_pkg::ST_VALUE;
        do_num   = 1'b0;
        do_len   = 1'b0;
        do_trunc = 1'b0;
        sh       = '0;
        nbytes   = '0;
        maxb     = '0;
        u32      = '0;
        u64      = '0;

        case (i_state.phase)
            svsd_pkg::PH_IDLE: begin
                n.kind       = i_kind;
                n.zigzag     = i_zigzag;
                n.acc        = '0;
                n.idx        = '0;
                n.chars_left = '0;
                n.partial    = '0;
                n.cont_left  = '0;
                case (i_kind)
                    svsd_pkg::KIND_BYTE: begin
                        r.have  = 1'b1;
                        r.value = {{56{b[7]}}, b};
                        r.last  = 1'b1;
                    end
                    svsd_pkg::KIND_BOOL: begin
                        r.have  = 1'b1;
                        r.value = {63'd0, (b == 8'd1)};
                        r.last  = 1'b1;
                    end
                    svsd_pkg::KIND_SHORT, svsd_pkg::KIND_INT, svsd_pkg::KIND_LONG: begin
                        n.phase = svsd_pkg::PH_FIXED;
                        do_num  = 1'b1;
                    end
                    svsd_pkg::KIND_VARINT32, svsd_pkg::KIND_VARINT64: begin
                        n.phase = svsd_pkg::PH_VARINT;
                        do_num  = 1'b1;
                    end
                    default: begin
                        if (!b[7]) begin
                            r.have   = 1'b1;
                            r.value  = {56'd0, b};
                            n.phase  = svsd_pkg::PH_ASCII;
                            do_trunc = 1'b1;
                        end else begin
                            n.acc = {58'd0, b[5:0]};
                            n.idx = 4'd1;
                            if (b[6]) begin
                                n.phase  = svsd_pkg::PH_LEN;
                                do_trunc = 1'b1;
                            end else begin
                                do_len = 1'b1;
                            end
                        end
                    end
                endcase
            end
            svsd_pkg::PH_FIXED, svsd_pkg::PH_VARINT: begin
                do_num = 1'b1;
            end
            svsd_pkg::PH_ASCII: begin
                r.have = 1'b1;
                if (b[7]) begin
                    r.value = {57'd0, b[6:0]};
                    r.last  = 1'b1;
                    n.phase = svsd_pkg::PH_IDLE;
                end else begin
                    r.value = {56'd0, b};
                end
                do_trunc = 1'b1;
            end
            svsd_pkg::PH_LEN: begin
                sh    = 7'd6 + ({3'd0, i_state.idx} - 7'd1) * 7'd7;
                n.acc = i_state.acc | ({57'd0, b[6:0]} << sh);
                n.idx = i_state.idx + 4'd1;
                if (b[7] && (n.idx < svsd_pkg::LEN_MAX_BYTES)) begin
                    do_trunc = 1'b1;
                end else begin
                    do_len = 1'b1;
                end
            end
            svsd_pkg::PH_UTF8: begin
                if (i_state.cont_left == 2'd0) begin
                    if (!b[7]) begin
                        n.partial        = {8'd0, b};
                        n.chars_left     = i_state.chars_left - 32'd1;
                        r.have           = 1'b1;
                        r.value          = {56'd0, b};
                        r.last           = (n.chars_left == 32'd0);
                        do_trunc         = 1'b1;
                    end else if (b[7:4] inside {4'hC, 4'hD}) begin
                        n.partial   = {5'd0, b[4:0], 6'd0};
                        n.cont_left = 2'd1;
                        do_trunc    = 1'b1;
                    end else if (b[7:4] == 4'hE) begin
                        n.partial   = {b[3:0], 12'd0};
                        n.cont_left = 2'd2;
                        do_trunc    = 1'b1;
                    end else begin
                        r.have   = 1'b1;
                        r.status = svsd_pkg::ST_BAD_LEAD;
                        r.last   = 1'b1;
                        n.phase  = svsd_pkg::PH_IDLE;
                    end
                end else if (i_state.cont_left == 2'd2) begin
                    n.partial   = i_state.partial | {4'd0, b[5:0], 6'd0};
                    n.cont_left = 2'd1;
                    do_trunc    = 1'b1;
                end else begin
                    n.partial    = i_state.partial | {10'd0, b[5:0]};
                    n.cont_left  = 2'd0;
                    n.chars_left = i_state.chars_left - 32'd1;
                    r.have       = 1'b1;
                    r.value      = {48'd0, n.partial};
                    r.last       = (n.chars_left == 32'd0);
                    do_trunc     = 1'b1;
                end
                if (r.have && r.last && (r.status == svsd_pkg::ST_VALUE)) begin
                    n.phase = svsd_pkg::PH_IDLE;
                end
            end
            default: begin
                n.phase = svsd_pkg::PH_IDLE;
            end
        endcase

        // fixed-width and varint bytes
        if (do_num) begin
            do_trunc = 1'b1;
            if (n.phase == svsd_pkg::PH_FIXED) begin
                case (n.kind)
                    svsd_pkg::KIND_SHORT: nbytes = 4'd2;
                    svsd_pkg::KIND_INT:   nbytes = 4'd4;
                    default:              nbytes = 4'd8;
                endcase
                n.acc = {n.acc[55:0], b};
                n.idx = n.idx + 4'd1;
                if (n.idx >= nbytes) begin
                    r.have  = 1'b1;
                    r.last  = 1'b1;
                    n.phase = svsd_pkg::PH_IDLE;
                    case (n.kind)
                        svsd_pkg::KIND_SHORT: r.value = {{48{n.acc[15]}}, n.acc[15:0]};
                        svsd_pkg::KIND_INT:   r.value = {{32{n.acc[31]}}, n.acc[31:0]};
                        default:              r.value = n.acc;
                    endcase
                end
            end else begin
                maxb = (n.kind == svsd_pkg::KIND_VARINT32) ? svsd_pkg::VARINT32_MAX_BYTES
                                                          : svsd_pkg::VARINT64_MAX_BYTES;
                if ((n.kind != svsd_pkg::KIND_VARINT32) &&
                    (n.idx == svsd_pkg::VARINT64_LAST_IDX)) begin
                    n.acc = n.acc | {b, 56'd0};
                end else begin
                    sh    = {3'd0, n.idx} * 7'd7;
                    n.acc = n.acc | ({57'd0, b[6:0]} << sh);
                end
                n.idx = n.idx + 4'd1;
                if (!b[7] || (n.idx >= maxb)) begin
                    r.have  = 1'b1;
                    r.last  = 1'b1;
                    n.phase = svsd_pkg::PH_IDLE;
                    if (n.kind == svsd_pkg::KIND_VARINT32) begin
                        u32 = n.acc[31:0];
                        if (n.zigzag) begin
                            u32 = (u32 >> 1) ^ {32{u32[0]}};
                        end
                        r.value = {{32{u32[31]}}, u32};
                    end else begin
                        u64 = n.acc;
                        if (n.zigzag) begin
                            u64 = (u64 >> 1) ^ {64{u64[0]}};
                        end
                        r.value = u64;
                    end
                end
            end
        end

        // length prefix complete
        if (do_len) begin
            do_trunc = 1'b1;
            if (n.acc[31:0] == 32'd0) begin
                r.have   = 1'b1;
                r.status = svsd_pkg::ST_NULL;
                r.last   = 1'b1;
                n.phase  = svsd_pkg::PH_IDLE;
            end else if (n.acc[31:0] == 32'd1) begin
                r.have   = 1'b1;
                r.status = svsd_pkg::ST_EMPTY;
                r.last   = 1'b1;
                n.phase  = svsd_pkg::PH_IDLE;
            end else begin
                n.chars_left = n.acc[31:0] - 32'd1;
                n.cont_left  = 2'd0;
                n.phase      = svsd_pkg::PH_UTF8;
            end
        end

        // end of buffer before the value or string is done
        if (do_trunc && i_end_of_buffer && (n.phase != svsd_pkg::PH_IDLE)) begin
            r.have   = 1'b1;
            r.value  = '0;
            r.status = svsd_pkg::ST_TRUNCATED;
            r.last   = 1'b1;
            n.phase  = svsd_pkg::PH_IDLE;
        end
    end

    assign o_state  = n;
    assign o_result = r;

endmodule

[sv/serialized_value_stream_decoder_core.sv]
// top level of the serialized value stream decoder: beat register, decoder state, result register
//
// Decodes one serialized byte per beat and sustains one byte per clock cycle while the output
// register is not blocked by a stall. Each byte is captured in an input register, the decoder
// state and the result are updated by one stage of combinational logic, and a result is held in
// an output register until taken. A byte that finishes nothing (the inner bytes of a short,
// int, long, varint, length prefix or multi-byte character) gives no result.
// Kind and zigzag are sampled only on the first byte of a value. Status other than a plain value
// (null, empty, truncated, bad lead byte) always comes with value zero and last set.
module serialized_value_stream_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [svsd_pkg::KIND_W-1:0]         i_kind,
    input  logic                                i_zigzag,
    input  logic [svsd_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_end_of_buffer,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [svsd_pkg::VALUE_W-1:0]        o_value,
    output logic [svsd_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_last
);

    logic                              r_s1_valid;
    logic                              n_s1_valid;
    logic [svsd_pkg::KIND_W-1:0]       r_kind;
    logic                              r_zigzag;
    logic [svsd_pkg::BYTE_W-1:0]       r_data_byte;
    logic                              r_eob;

    svsd_pkg::t_dec_state              r_state;
    svsd_pkg::t_dec_state              n_state;
    svsd_pkg::t_result                 step_res;

    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [svsd_pkg::VALUE_W-1:0]      r_value;
    logic [svsd_pkg::STATUS_W-1:0]     r_status;
    logic                              r_last;

    logic                              out_free;
    logic                              s1_move;
    logic                              in_accept;

    svsd_step u_step (
        .i_state         (r_state),
        .i_kind          (r_kind),
        .i_zigzag        (r_zigzag),
        .i_data_byte     (r_data_byte),
        .i_end_of_buffer (r_eob),
        .o_state         (n_state),
        .o_result        (step_res)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move && step_res.have) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: svsd_pkg::PH_IDLE, default: '0};
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (s1_move) begin
                r_state <= n_state;
            end
        end
    end

    // beat and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind      <= i_kind;
            r_zigzag    <= i_zigzag;
            r_data_byte <= i_data_byte;
            r_eob       <= i_end_of_buffer;
        end
        if (s1_move && step_res.have) begin
            r_value  <= step_res.value;
            r_status <= step_res.status;
            r_last   <= step_res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

    // error and string status always ends the value with a zero payload
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != svsd_pkg::ST_VALUE)) |-> (r_last && (r_value == '0)))
        else $error("non-value status without last or with nonzero value");

    // decoder state holds while the result register is blocked
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_state))
        else $error("decoder state moved under output stall");

    // upstream is stalled only when a byte is waiting in the beat register and the result register is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked beat");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule
